// ----- rtl/core/rrf_pkg.sv -----
package rrf_pkg;

    localparam int MAX_CENTRAL   = 32;
    localparam int COORD_BITS    = 24;
    localparam int IN_COORD_BITS = 25;
    localparam int RADIUS_BITS   = 50;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(64'd64000000);

    // store addressing
    localparam int ADDR_W = (MAX_CENTRAL > 1) ? $clog2(MAX_CENTRAL) : 1;
    localparam int CNT_W  = $clog2(MAX_CENTRAL + 1);

    // arithmetic widths
    localparam int EXT_W  = (IN_COORD_BITS > COORD_BITS) ? IN_COORD_BITS : COORD_BITS;
    localparam int DIFF_W = EXT_W + 1;
    localparam int SQ_W   = 2 * EXT_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > RADIUS_BITS) ? SUM_W : RADIUS_BITS;

    // one store entry holds x, y and z
    localparam int ENTRY_W = 3 * COORD_BITS;

    // APB map: one 64-bit register at byte address 0
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic REG_RADIUS_SQ = 1'b0;

    typedef logic signed [IN_COORD_BITS-1:0] t_in_coord;
    typedef logic signed [COORD_BITS-1:0]    t_coord;

    // clamp an incoming coordinate to the stored range
    function automatic t_coord sat_coord(input t_in_coord v);
        logic signed [EXT_W-1:0] ve;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        ve = EXT_W'(v);
        hi = {{(EXT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
        lo = ~hi;
        if (ve > hi) begin
            return hi[COORD_BITS-1:0];
        end else if (ve < lo) begin
            return lo[COORD_BITS-1:0];
        end else begin
            return ve[COORD_BITS-1:0];
        end
    endfunction

    // |a - b| of a probe and a stored coordinate
    function automatic logic [EXT_W-1:0] abs_diff(input t_in_coord a, input t_coord b);
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] m;
        d = DIFF_W'(a) - DIFF_W'(b);
        m = d[DIFF_W-1] ? -d : d;
        return m[EXT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/rrf_ram.sv -----
module rrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/core/residue_radius_flagger.sv -----
// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_ready     i_req_type, i_atom_x/y/z,
//                                                  i_residue_last, i_restart_set
// out       source     o_out_valid / i_out_ready   o_residue_in_range, o_set_overflowed
// cfg       APB slave  psel, penable, pready       paddr, pwdata, prdata (radius_sq)
//
// Central load: taken while idle, written straight into the store unless it is full.
// Probe: taken while idle, then one store read for each of N stored central atoms,
// the four pipeline stages draining, and a verdict if it ends a residue; no new
// item is taken before the probe is through; an empty set skips the store reads.
// Synchronous active-low reset; the store itself is not cleared, only the count.
// A finished verdict sits in the output register; a further residue end waits
// only if that register is still full.
module residue_radius_flagger (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  rrf_pkg::t_in_coord             i_atom_x,
    input  rrf_pkg::t_in_coord             i_atom_y,
    input  rrf_pkg::t_in_coord             i_atom_z,
    input  logic                           i_residue_last,
    input  logic                           i_restart_set,
    // verdict output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_residue_in_range,
    output logic                           o_set_overflowed,
    // APB
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrf_pkg::PADDR_W-1:0]    paddr,
    input  logic [rrf_pkg::PDATA_W-1:0]    pwdata,
    output logic [rrf_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    import rrf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    // control
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic               r_hit, n_hit;
    logic               r_ovf, n_ovf;
    logic               r_v1, r_v2, r_v3, r_v4;
    logic               r_out_valid, n_out_valid;
    logic [RADIUS_BITS-1:0] r_radius;

    // payload
    t_in_coord          r_px, r_py, r_pz;
    logic               r_last;
    logic [EXT_W-1:0]   r_ax, r_ay, r_az;
    logic [SQ_W-1:0]    r_sqx, r_sqy, r_sqz;
    logic [SUM_W-1:0]   r_sum;
    logic               r_res_in_range, r_res_ovf;
    logic               n_emit;

    // store interface
    logic               s_accept;
    logic               s_load;
    logic               s_issue;
    logic               s_we;
    logic [CNT_W-1:0]   s_base;
    logic [ADDR_W-1:0]  s_waddr;
    logic [ENTRY_W-1:0] s_wdata;
    logic [ENTRY_W-1:0] s_rdata;
    t_coord             s_cx, s_cy, s_cz;
    logic               s_pipe_busy;
    logic               s_slot_free;
    logic               s_cfg_wr;

    assign o_in_ready = (r_state == S_IDLE);
    assign s_accept   = i_in_valid && o_in_ready;
    assign s_load     = s_accept && !i_req_type;

    // restart empties the set before this atom is stored
    assign s_base  = i_restart_set ? '0 : r_count;
    assign s_we    = s_load && (s_base < CNT_W'(MAX_CENTRAL));
    assign s_waddr = s_base[ADDR_W-1:0];
    assign s_wdata = {sat_coord(i_atom_z), sat_coord(i_atom_y), sat_coord(i_atom_x)};

    assign s_issue = (r_state == S_SCAN);

    rrf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CENTRAL)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (r_idx),
        .o_rdata (s_rdata)
    );

    assign s_cx = s_rdata[COORD_BITS-1:0];
    assign s_cy = s_rdata[2*COORD_BITS-1:COORD_BITS];
    assign s_cz = s_rdata[3*COORD_BITS-1:2*COORD_BITS];

    assign s_pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign s_slot_free = !r_out_valid || i_out_ready;

    // APB: zero wait states
    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_RADIUS_SQ);
    assign prdata   = (paddr[PADDR_W-1] == REG_RADIUS_SQ) ? PDATA_W'(r_radius) : '0;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_ovf       = r_ovf;
        n_emit      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;

        // hit from the last pipeline stage; strict less-than
        if (r_v4 && (CMP_W'(r_sum) < CMP_W'(r_radius))) begin
            n_hit = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (s_load) begin
                    if (s_we) begin
                        n_count = s_base + CNT_W'(1);
                        n_ovf   = i_restart_set ? 1'b0 : r_ovf;
                    end else begin
                        n_count = s_base;
                        n_ovf   = 1'b1;
                    end
                end else if (s_accept) begin
                    n_idx   = '0;
                    n_state = (r_count == '0) ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN: begin
                // one store read per cycle
                if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                if (!s_pipe_busy) begin
                    if (!r_last) begin
                        n_state = S_IDLE;
                    end else if (s_slot_free) begin
                        n_emit      = 1'b1;
                        n_out_valid = 1'b1;
                        n_hit       = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_ovf       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            r_radius    <= RADIUS_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_hit       <= n_hit;
            r_ovf       <= n_ovf;
            r_v1        <= s_issue;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= n_out_valid;
            if (s_cfg_wr) begin
                r_radius <= pwdata[RADIUS_BITS-1:0];
            end
        end

        // probe latch
        if (s_accept && i_req_type) begin
            r_px   <= i_atom_x;
            r_py   <= i_atom_y;
            r_pz   <= i_atom_z;
            r_last <= i_residue_last;
        end

        // distance pipeline: |d|, d^2, sum
        r_ax  <= abs_diff(r_px, s_cx);
        r_ay  <= abs_diff(r_py, s_cy);
        r_az  <= abs_diff(r_pz, s_cz);
        r_sqx <= r_ax * r_ax;
        r_sqy <= r_ay * r_ay;
        r_sqz <= r_az * r_az;
        r_sum <= SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);

        if (n_emit) begin
            r_res_in_range <= r_hit;
            r_res_ovf      <= r_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_residue_in_range = r_res_in_range;
    assign o_set_overflowed   = r_res_ovf;

    // never take an item while distance results are still in flight
    a_ready_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !s_pipe_busy)
        else $error("input ready with distance pipeline busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CENTRAL))
        else $error("central count beyond store depth");

    a_restart_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_load && i_restart_set) |=> (r_count == CNT_W'(1) && !r_ovf))
        else $error("restart did not leave exactly one central atom");

    a_verdict_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DRAIN && $past(r_last)))
        else $error("verdict raised outside the end of a residue");

endmodule

// ----- verif/residue_radius_flagger_test.sv -----
`timescale 1ns / 100ps

module residue_radius_flagger_test;
    import rrf_pkg::*;

    // ------------------------------------------------------------------
    // Run sizing
    // ------------------------------------------------------------------
    localparam int ITEM_TARGET     = 1650;
    localparam int PHASES          = 8;
    localparam int LONG_GAP_MAX    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    // worst probe: full store read plus the distance pipeline, with margin
    localparam int SETTLE_CYCLES   = 2 * (MAX_CENTRAL + 5);
    // worst item: slowest probe, longest send gap, longest receive stall;
    // item count allows for phases running over their budget
    localparam int CYCLE_LIMIT     =
        4 * (ITEM_TARGET + 400) * (MAX_CENTRAL + 5 + 2 * LONG_GAP_MAX) + 50000;

    // ------------------------------------------------------------------
    // Coordinate and register constants
    // ------------------------------------------------------------------
    localparam int     COORD_LIM = 9999999;   // field range, milliangstroms
    localparam longint STORE_HI  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint STORE_LO  = -STORE_HI - 1;

    localparam logic [PADDR_W-1:0]     RADIUS_ADDR = PADDR_W'(8 * int'(REG_RADIUS_SQ));
    localparam logic [RADIUS_BITS-1:0] RADIUS_MAX  = '1;

    localparam t_in_coord C_MAX     = t_in_coord'(COORD_LIM);
    localparam t_in_coord C_MIN     = t_in_coord'(-COORD_LIM);
    localparam t_in_coord S_HI      = t_in_coord'(STORE_HI);
    localparam t_in_coord S_LO      = t_in_coord'(STORE_LO);
    localparam t_in_coord ORIGIN    = '0;
    localparam t_in_coord M_ONE     = t_in_coord'(-1);
    // 8 angstrom default radius: one short of it, and exactly on it
    localparam t_in_coord NEAR_8A   = t_in_coord'(7999);
    localparam t_in_coord NEAR_8A_M = t_in_coord'(7998);
    localparam t_in_coord ON_8A_NEG = t_in_coord'(-8000);

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_PROBE = 1'b1
    } t_req;

    typedef struct packed {
        t_req      kind;
        t_in_coord x;
        t_in_coord y;
        t_in_coord z;
        logic      last;
        logic      restart;
    } t_atom;

    typedef struct packed {
        logic in_range;
        logic overflowed;
    } t_verdict;

    // pinned rows carry a verdict typed in by hand; the others use the predictor
    typedef struct packed {
        t_atom    atom;
        logic     pinned;
        t_verdict want;
    } t_row;

    // ------------------------------------------------------------------
    // Directed table, run at the reset radius (8 angstroms)
    // ------------------------------------------------------------------
    localparam int DIRECTED_ROWS = 18;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // empty central set never hits
        '{'{REQ_PROBE, ORIGIN, ORIGIN, ORIGIN, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0}},
        // restart flag on a probe is ignored, set still empty
        '{'{REQ_PROBE, C_MIN, C_MAX, C_MIN, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0}},
        // first central atom at the origin
        '{'{REQ_LOAD, ORIGIN, ORIGIN, ORIGIN, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}},
        // just short of the radius
        '{'{REQ_PROBE, NEAR_8A, ORIGIN, ORIGIN, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0}},
        // exactly on the radius: strict test, no hit
        '{'{REQ_PROBE, ORIGIN, ON_8A_NEG, ORIGIN, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0}},
        // hit early in a residue, miss at its end: OR holds
        '{'{REQ_PROBE, ORIGIN, ORIGIN, ORIGIN, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
        '{'{REQ_PROBE, C_MAX, C_MAX, C_MAX, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0}},
        // miss, then a central load mid-residue (its last mark ignored)
        '{'{REQ_PROBE, C_MIN, C_MIN, C_MIN, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
        '{'{REQ_LOAD, C_MIN, C_MIN, C_MIN, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
        // the load was clamped to the store's negative limit
        '{'{REQ_PROBE, S_LO, S_LO, S_LO, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0}},
        // positive clamp
        '{'{REQ_LOAD, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
        '{'{REQ_PROBE, S_HI, S_HI, S_HI, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0}},
        // probe keeps its full width: far from the clamped atom
        '{'{REQ_PROBE, C_MAX, C_MAX, C_MAX, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0}},
        // restart: only the new atom remains
        '{'{REQ_LOAD, M_ONE, M_ONE, M_ONE, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}},
        '{'{REQ_PROBE, M_ONE, M_ONE, NEAR_8A_M, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
        // would hit the origin atom, which restart threw away
        '{'{REQ_PROBE, NEAR_8A, ORIGIN, ORIGIN, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0}},
        '{'{REQ_PROBE, ORIGIN, ORIGIN, ORIGIN, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}},
        '{'{REQ_PROBE, C_MAX, C_MIN, C_MAX, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}}
    };

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_req_type;
    t_in_coord          i_atom_x;
    t_in_coord          i_atom_y;
    t_in_coord          i_atom_z;
    logic               i_residue_last;
    logic               i_restart_set;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_residue_in_range;
    logic               o_set_overflowed;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    residue_radius_flagger u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_atom_x           (i_atom_x),
        .i_atom_y           (i_atom_y),
        .i_atom_z           (i_atom_z),
        .i_residue_last     (i_residue_last),
        .i_restart_set      (i_restart_set),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_residue_in_range (o_residue_in_range),
        .o_set_overflowed   (o_set_overflowed),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Neighbour-search predictor: own copy of the store, counters and radius
    // ------------------------------------------------------------------
    t_coord                 ctr_x [MAX_CENTRAL];
    t_coord                 ctr_y [MAX_CENTRAL];
    t_coord                 ctr_z [MAX_CENTRAL];
    int                     ctr_count    = 0;
    bit                     res_hit      = 1'b0;
    bit                     ovf_flag     = 1'b0;
    logic [RADIUS_BITS-1:0] model_radius = RADIUS_RESET;

    t_verdict verdicts_due [$];
    int       fault_count    = 0;
    int       cycle_count    = 0;
    bit       steady         = 1'b0;   // no idling on either side
    bit       hold_off_asked = 1'b0;

    function automatic t_coord clamp_store(input t_in_coord v);
        longint w;
        w = longint'(v);
        if (w > STORE_HI) return t_coord'(STORE_HI);
        if (w < STORE_LO) return t_coord'(STORE_LO);
        return t_coord'(w);
    endfunction

    // update the predicted state for one accepted item; flags a verdict
    task automatic advance_model(input t_atom a, output bit produced, output t_verdict v);
        longint dx;
        longint dy;
        longint dz;
        longint dsq;
        produced = 1'b0;
        v        = '0;
        if (a.kind == REQ_LOAD) begin
            if (a.restart) begin
                ctr_count = 0;
                ovf_flag  = 1'b0;
            end
            if (ctr_count < MAX_CENTRAL) begin
                ctr_x[ctr_count] = clamp_store(a.x);
                ctr_y[ctr_count] = clamp_store(a.y);
                ctr_z[ctr_count] = clamp_store(a.z);
                ctr_count++;
            end else begin
                ovf_flag = 1'b1;
            end
        end else begin
            for (int i = 0; i < ctr_count; i++) begin
                dx  = longint'($signed(a.x)) - longint'(ctr_x[i]);
                dy  = longint'($signed(a.y)) - longint'(ctr_y[i]);
                dz  = longint'($signed(a.z)) - longint'(ctr_z[i]);
                dsq = dx * dx + dy * dy + dz * dz;
                if (dsq < longint'(model_radius)) res_hit = 1'b1;
            end
            if (a.last) begin
                produced     = 1'b1;
                v.in_range   = res_hit;
                v.overflowed = ovf_flag;
                res_hit      = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Pacing helpers
    // ------------------------------------------------------------------
    // mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, LONG_GAP_MAX);
    endfunction

    function automatic t_in_coord fit_coord(input longint v);
        if (v > COORD_LIM)  return C_MAX;
        if (v < -COORD_LIM) return C_MIN;
        return t_in_coord'(v);
    endfunction

    function automatic t_in_coord scatter(input longint centre, input int s);
        return fit_coord(centre + longint'($urandom_range(0, 2 * s)) - s);
    endfunction

    // anchor coordinate of a cluster; a quarter are drawn near the field edge, around the store's clamp
    function automatic longint pick_anchor();
        longint m;
        if ($urandom_range(0, 3) == 0) begin
            m = longint'($urandom_range(8000000, COORD_LIM));
            return ($urandom_range(0, 1) != 0) ? m : -m;
        end
        return longint'($urandom_range(0, 2 * COORD_LIM)) - COORD_LIM;
    endfunction

    function automatic t_atom make_load(input longint ax, input longint ay, input longint az,
                                        input int s, input bit restart);
        t_atom a;
        a.kind    = REQ_LOAD;
        a.x       = scatter(ax, s);
        a.y       = scatter(ay, s);
        a.z       = scatter(az, s);
        a.last    = 1'($urandom_range(0, 1));   // ignored on a load
        a.restart = restart;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Item sender: drive at the falling edge, watch the handshake at the
    // rising edge, and predict at the edge where the item is taken
    // ------------------------------------------------------------------
    task automatic offer_atom(input t_atom a, input bit pinned, input t_verdict want);
        int       gap;
        bit       produced;
        t_verdict v;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type     = a.kind;
        i_atom_x       = a.x;
        i_atom_y       = a.y;
        i_atom_z       = a.z;
        i_residue_last = a.last;
        i_restart_set  = a.restart;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        advance_model(a, produced, v);
        if (produced) verdicts_due.push_back(pinned ? want : v);
    endtask

    // APB write of radius_sq, then a read-back
    task automatic program_radius(input logic [RADIUS_BITS-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = RADIUS_ADDR;
        pwdata  = PDATA_W'(value);
        @(negedge i_clk) penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        model_radius = value;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk) penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[RADIUS_BITS-1:0] !== value) begin
            $error("radius_sq: expected %0d, got %0d", value, prdata[RADIUS_BITS-1:0]);
            fault_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // park the input, let every verdict arrive and the probe pipe empty
    task automatic settle();
        @(negedge i_clk) i_in_valid = 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // One random phase: clusters of central atoms, then residues of probes
    // scattered round the cluster, with noise and broken sequences mixed in
    // ------------------------------------------------------------------
    task automatic run_phase(input int reach, input int budget);
        int     sent;
        int     k;
        int     groups;
        int     n;
        int     pick;
        int     idx;
        longint ax;
        longint ay;
        longint az;
        t_atom  a;
        sent = 0;
        while (sent < budget) begin
            ax   = pick_anchor();
            ay   = pick_anchor();
            az   = pick_anchor();
            pick = $urandom_range(0, 99);
            if (pick < 12)
                k = $urandom_range(MAX_CENTRAL + 1, MAX_CENTRAL + 8);   // overfills the store
            else if (pick < 25)
                k = $urandom_range(MAX_CENTRAL - 8, MAX_CENTRAL);
            else
                k = $urandom_range(1, 8);
            for (int i = 0; i < k; i++) begin
                a = make_load(ax, ay, az, reach, (i == 0) || ($urandom_range(0, 99) < 3));
                offer_atom(a, 1'b0, '0);
                sent++;
            end
            groups = $urandom_range(2, 12);
            for (int g = 0; g < groups; g++) begin
                n = $urandom_range(1, 4);
                for (int m = 0; m < n; m++) begin
                    if ($urandom_range(0, 99) < 4) begin
                        // central load dropped into an open residue
                        a = make_load(ax, ay, az, reach, $urandom_range(0, 99) < 20);
                        offer_atom(a, 1'b0, '0);
                        sent++;
                    end
                    a.kind = REQ_PROBE;
                    pick   = $urandom_range(0, 99);
                    if (pick < 12) begin
                        a.x = scatter(0, COORD_LIM);
                        a.y = scatter(0, COORD_LIM);
                        a.z = scatter(0, COORD_LIM);
                    end else if (pick < 27 && ctr_count > 0) begin
                        // sits exactly on a stored atom
                        idx = $urandom_range(0, ctr_count - 1);
                        a.x = t_in_coord'(ctr_x[idx]);
                        a.y = t_in_coord'(ctr_y[idx]);
                        a.z = t_in_coord'(ctr_z[idx]);
                    end else begin
                        a.x = scatter(ax, 2 * reach);
                        a.y = scatter(ay, 2 * reach);
                        a.z = scatter(az, 2 * reach);
                    end
                    // now and then a residue is left open into the next one
                    a.last    = (m == n - 1) && ($urandom_range(0, 99) >= 5);
                    a.restart = 1'($urandom_range(0, 1));
                    offer_atom(a, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Verdict checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : verdict_check
        t_verdict due;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (verdicts_due.size() == 0) begin
                $error("unexpected verdict: residue_in_range %0b, set_overflowed %0b",
                       o_residue_in_range, o_set_overflowed);
                fault_count++;
            end else begin
                due = verdicts_due.pop_front();
                if (o_residue_in_range !== due.in_range) begin
                    $error("residue_in_range: expected %0b, got %0b",
                           due.in_range, o_residue_in_range);
                    fault_count++;
                end
                if (o_set_overflowed !== due.overflowed) begin
                    $error("set_overflowed: expected %0b, got %0b",
                           due.overflowed, o_set_overflowed);
                    fault_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Verdict receiver pacing; a requested hold-off is counted out here
    // so the sender keeps offering and the block backs up
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_asked) begin
                hold_off_asked = 1'b0;
                @(negedge i_clk) i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk) i_out_ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_ready = 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                     r;
        int                     reach;
        int                     budget;
        logic [RADIUS_BITS-1:0] rsq;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_LOAD;
        i_atom_x       = '0;
        i_atom_y       = '0;
        i_atom_z       = '0;
        i_residue_last = 1'b0;
        i_restart_set  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed rows run against the reset radius
        foreach (DIRECTED[i])
            offer_atom(DIRECTED[i].atom, DIRECTED[i].pinned, DIRECTED[i].want);
        settle();

        budget = (ITEM_TARGET - DIRECTED_ROWS) / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            steady = 1'b0;
            case (p)
                0, 4: begin
                    r     = $urandom_range(1000, 50000);
                    rsq   = RADIUS_BITS'(longint'(r) * r + $urandom_range(0, 2 * r));
                    reach = r;
                end
                1: begin
                    rsq   = RADIUS_MAX;      // everything in the set is near
                    reach = 3000000;
                end
                2: begin
                    rsq   = '0;              // nothing can be near
                    reach = 8000;
                end
                3: begin
                    rsq   = RADIUS_BITS'(1); // only exact coincidence hits
                    reach = 3;
                end
                5: begin
                    r      = $urandom_range(50000, 1000000);
                    rsq    = RADIUS_BITS'(longint'(r) * r);
                    reach  = r;
                    steady = 1'b1;
                end
                6: begin
                    r     = $urandom_range(2, 200);
                    rsq   = RADIUS_BITS'(longint'(r) * r);
                    reach = r;
                end
                default: begin
                    rsq   = RADIUS_RESET;
                    reach = 8000;
                end
            endcase
            program_radius(rsq);
            if (p == 4) hold_off_asked = 1'b1;
            run_phase(reach, budget);
            settle();
        end

        if (fault_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rrf_pkg.sv
rtl/core/rrf_ram.sv
rtl/core/residue_radius_flagger.sv
verif/residue_radius_flagger_test.sv
